// File: sv/arsc_pkg.sv
// Shared types and constants of the accelerometer RMS sleep-stage classifier.
package arsc_pkg;

	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_TOGGLE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	localparam logic [1:0] STAGE_AWAKE = 2'd0;
	localparam logic [1:0] STAGE_LIGHT = 2'd1;
	localparam logic [1:0] STAGE_DEEP  = 2'd2;

	localparam logic [1:0] REG_WINDOW_SAMPLES  = 2'd0;
	localparam logic [1:0] REG_WINDOW_SECONDS  = 2'd1;
	localparam logic [1:0] REG_AWAKE_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_LIGHT_THRESHOLD = 2'd3;

	localparam logic [15:0] ONE_G = 16'd16384;

	localparam logic [5:0] SQRT_STEPS = 6'd24;
	localparam logic [5:0] DIV_STEPS  = 6'd48;
	localparam logic [5:0] SQ_STEPS   = 6'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_SQ, ST_MAG_INIT, ST_MAG, ST_MOTION, ST_ACC, ST_CHECK,
		ST_DIV_INIT, ST_DIV, ST_RMS_INIT, ST_RMS, ST_CLASSIFY, ST_READ, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_SQRT_MAG, OP_SQRT_MEAN, OP_SQRT_STEP, OP_MOTION,
		OP_ACC, OP_DIV_INIT, OP_DIV_STEP, OP_CLASSIFY, OP_MISC, OP_READ, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       mon;
		logic       close;
	} dp_status_t;

endpackage

// File: sv/accel_rms_sleep_stage_classifier_unit.sv
// Top level of the accelerometer RMS sleep-stage classifier.
// Each input transfer carries one event and produces exactly one output transfer. A sample
// taken while monitoring is on squares its three axes on one shared multiplier, takes the
// magnitude with a bit-serial square root, and accumulates the squared distance from 1 g. A
// sample that closes a window adds a restoring divider for the mean and a second square root
// for the RMS. Toggle and clear events, and samples while monitoring is off, go straight to
// the output state; a history read passes through the read state as well, since the history
// ring is a memory with a registered read port. The block works on one event at a time, and
// a finished result sits in the output register while the next event is already accepted
// and processed. The history ring holds HISTORY_DEPTH windows; entries beyond the fill count
// are reported as zero, so the ring needs no clearing after reset. Configuration writes are
// meant to happen only while the block is idle.
module accel_rms_sleep_stage_classifier_unit #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        rtc_now,
	input  logic [6:0]         hist_age,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               window_done,
	output logic [15:0]        rms_level,
	output logic [1:0]         sleep_state,
	output logic               monitor_on,
	output logic [31:0]        sleep_total,
	output logic [31:0]        deep_total,
	output logic [31:0]        turns,
	output logic [7:0]         slots_filled,
	output logic [31:0]        session_begin,
	output logic [1:0]         slot_state,
	output logic [31:0]        slot_time
);

	// Commands flow from the controller, status flows back.
	arsc_pkg::dp_cmd_t    cmd;
	arsc_pkg::dp_status_t status;

	arsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	arsc_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.rtc_now       (rtc_now),
		.hist_age      (hist_age),
		.window_done   (window_done),
		.rms_level     (rms_level),
		.sleep_state   (sleep_state),
		.monitor_on    (monitor_on),
		.sleep_total   (sleep_total),
		.deep_total    (deep_total),
		.turns         (turns),
		.slots_filled  (slots_filled),
		.session_begin (session_begin),
		.slot_state    (slot_state),
		.slot_time     (slot_time)
	);

endmodule

// File: sv/arsc_ctrl.sv
// Controller state machine that sequences one event through the datapath.
module arsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  arsc_pkg::dp_status_t status,
	output arsc_pkg::dp_cmd_t    cmd
);

	arsc_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic out_valid_q, load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arsc_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd.op = arsc_pkg::OP_NONE;
		cmd.sel = cnt_q[1:0];
		load_out = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			arsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = arsc_pkg::OP_LOAD;
					state_d = arsc_pkg::ST_DISPATCH;
				end
			end
			arsc_pkg::ST_DISPATCH: begin
				cnt_d = '0;
				unique case (status.func)
					arsc_pkg::FUNC_SAMPLE: state_d = status.mon ? arsc_pkg::ST_SQ
						: arsc_pkg::ST_OUT;
					arsc_pkg::FUNC_READ: begin
						cmd.op = arsc_pkg::OP_READ;
						state_d = arsc_pkg::ST_READ;
					end
					default: begin
						cmd.op = arsc_pkg::OP_MISC;
						state_d = arsc_pkg::ST_OUT;
					end
				endcase
			end
			arsc_pkg::ST_SQ: begin
				cmd.op = arsc_pkg::OP_SQ;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == arsc_pkg::SQ_STEPS - 6'd1) state_d = arsc_pkg::ST_MAG_INIT;
			end
			arsc_pkg::ST_MAG_INIT: begin
				cmd.op = arsc_pkg::OP_SQRT_MAG;
				cnt_d = '0;
				state_d = arsc_pkg::ST_MAG;
			end
			arsc_pkg::ST_MAG: begin
				cmd.op = arsc_pkg::OP_SQRT_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == arsc_pkg::SQRT_STEPS - 6'd1) state_d = arsc_pkg::ST_MOTION;
			end
			arsc_pkg::ST_MOTION: begin
				cmd.op = arsc_pkg::OP_MOTION;
				state_d = arsc_pkg::ST_ACC;
			end
			arsc_pkg::ST_ACC: begin
				cmd.op = arsc_pkg::OP_ACC;
				state_d = arsc_pkg::ST_CHECK;
			end
			arsc_pkg::ST_CHECK: begin
				state_d = status.close ? arsc_pkg::ST_DIV_INIT : arsc_pkg::ST_OUT;
			end
			arsc_pkg::ST_DIV_INIT: begin
				cmd.op = arsc_pkg::OP_DIV_INIT;
				cnt_d = '0;
				state_d = arsc_pkg::ST_DIV;
			end
			arsc_pkg::ST_DIV: begin
				cmd.op = arsc_pkg::OP_DIV_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == arsc_pkg::DIV_STEPS - 6'd1) state_d = arsc_pkg::ST_RMS_INIT;
			end
			arsc_pkg::ST_RMS_INIT: begin
				cmd.op = arsc_pkg::OP_SQRT_MEAN;
				cnt_d = '0;
				state_d = arsc_pkg::ST_RMS;
			end
			arsc_pkg::ST_RMS: begin
				cmd.op = arsc_pkg::OP_SQRT_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == arsc_pkg::SQRT_STEPS - 6'd1) state_d = arsc_pkg::ST_CLASSIFY;
			end
			arsc_pkg::ST_CLASSIFY: begin
				cmd.op = arsc_pkg::OP_CLASSIFY;
				state_d = arsc_pkg::ST_OUT;
			end
			arsc_pkg::ST_READ: state_d = arsc_pkg::ST_OUT;
			arsc_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = arsc_pkg::OP_OUT;
					load_out = 1'b1;
					state_d = arsc_pkg::ST_IDLE;
				end
			end
			default: state_d = arsc_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	// A waiting result is never dropped.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped while stalled");

	// An accepted event is in flight, so no second one is taken next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second event taken while busy");

	// Square root iteration counts stay within their loops.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arsc_pkg::ST_MAG || state_q == arsc_pkg::ST_RMS
		|-> cnt_q < arsc_pkg::SQRT_STEPS)
		else $error("square root iteration count overrun");

	// A result is only loaded from the output state.
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> state_q == arsc_pkg::ST_OUT && !(out_valid_q && !out_ready))
		else $error("result loaded over a waiting one");

endmodule

// File: sv/arsc_dp.sv
// Datapath: squares, shared square root, divider, statistics and history ring.
module arsc_dp #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arsc_pkg::dp_cmd_t    cmd,
	output arsc_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [1:0]           func,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	input  logic [31:0]          rtc_now,
	input  logic [6:0]           hist_age,
	output logic                 window_done,
	output logic [15:0]          rms_level,
	output logic [1:0]           sleep_state,
	output logic                 monitor_on,
	output logic [31:0]          sleep_total,
	output logic [31:0]          deep_total,
	output logic [31:0]          turns,
	output logic [7:0]           slots_filled,
	output logic [31:0]          session_begin,
	output logic [1:0]           slot_state,
	output logic [31:0]          slot_time
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int IW = ((AW > 7) ? AW : 7) + 2;
	localparam int CW = ((FW > 7) ? FW : 7);
	localparam logic [IW-1:0] DEPTH_I = IW'(HISTORY_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_A = AW'(HISTORY_DEPTH - 1);

	logic [15:0] win_samples_q, win_seconds_q, awake_thr_q, light_thr_q;
	logic [1:0] func_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [31:0] rtc_q;
	logic [6:0] age_q;

	logic [47:0] square_sum_q;
	logic [15:0] window_count_q;
	logic [1:0] stage_q;
	logic was_asleep_q, mon_q, close_q;
	logic [31:0] sleep_q, deep_q, turns_q, session_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;

	logic [31:0] magsq_q, prod_q;
	logic [47:0] rad_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [47:0] dvd_q;
	logic [15:0] drem_q;
	logic done_q, hit_q;
	logic [15:0] rms_q;
	logic [33:0] rd_q;

	logic [33:0] ring_mem [HISTORY_DEPTH];

	// Shared multiplier.
	logic signed [16:0] mul_a;
	logic signed [33:0] mul_p;
	logic [15:0] mag, motion;
	always_comb begin
		mag = root_q[15:0];
		motion = (mag >= arsc_pkg::ONE_G) ? mag - arsc_pkg::ONE_G : arsc_pkg::ONE_G - mag;
		case (cmd.sel)
			2'd0: mul_a = {ax_q[15], ax_q};
			2'd1: mul_a = {ay_q[15], ay_q};
			default: mul_a = {az_q[15], az_q};
		endcase
		if (cmd.op == arsc_pkg::OP_MOTION) mul_a = {1'b0, motion};
		mul_p = mul_a * mul_a;
	end

	// Square root step, one result bit per cycle.
	logic [25:0] sq_rem, sq_trial;
	logic sq_ge;
	always_comb begin
		sq_rem = {rem_q[23:0], rad_q[47:46]};
		sq_trial = {root_q, 2'b01};
		sq_ge = sq_rem >= sq_trial;
	end

	// Restoring division step.
	logic [16:0] dv_t;
	logic dv_ge;
	always_comb begin
		dv_t = {drem_q, dvd_q[47]};
		dv_ge = dv_t >= {1'b0, window_count_q};
	end

	// Window bookkeeping for the sample being added.
	logic [15:0] count_inc;
	assign count_inc = window_count_q + 16'd1;

	// Classification of the finished window.
	logic [15:0] rms_now;
	logic [1:0] stage_new;
	always_comb begin
		rms_now = root_q[15:0];
		if (rms_now > awake_thr_q) stage_new = arsc_pkg::STAGE_AWAKE;
		else if (rms_now > light_thr_q) stage_new = arsc_pkg::STAGE_LIGHT;
		else stage_new = arsc_pkg::STAGE_DEEP;
	end

	// History address: newest minus age, modulo the depth.
	logic [IW-1:0] idx_sum, idx_mod;
	logic [CW-1:0] age_c, fill_c;
	logic [AW-1:0] rd_addr;
	always_comb begin
		idx_sum = IW'(head_q) + DEPTH_I - IW'(1) - IW'(age_q);
		idx_mod = (idx_sum >= DEPTH_I) ? idx_sum - DEPTH_I : idx_sum;
		rd_addr = idx_mod[AW-1:0];
		age_c = CW'(age_q);
		fill_c = CW'(fill_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == arsc_pkg::OP_CLASSIFY) ring_mem[head_q] <= {stage_new, rtc_q};
		if (cmd.op == arsc_pkg::OP_READ) rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_samples_q <= 16'd3000;
			win_seconds_q <= 16'd30;
			awake_thr_q <= 16'd1600;
			light_thr_q <= 16'd400;
			square_sum_q <= '0;
			window_count_q <= '0;
			stage_q <= arsc_pkg::STAGE_AWAKE;
			was_asleep_q <= 1'b0;
			mon_q <= 1'b1;
			close_q <= 1'b0;
			sleep_q <= '0;
			deep_q <= '0;
			turns_q <= '0;
			session_q <= '0;
			head_q <= '0;
			fill_q <= '0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
			func_q <= arsc_pkg::FUNC_SAMPLE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					arsc_pkg::REG_WINDOW_SAMPLES:  win_samples_q <= cfg_data;
					arsc_pkg::REG_WINDOW_SECONDS:  win_seconds_q <= cfg_data;
					arsc_pkg::REG_AWAKE_THRESHOLD: awake_thr_q <= cfg_data;
					arsc_pkg::REG_LIGHT_THRESHOLD: light_thr_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				arsc_pkg::OP_LOAD: begin
					func_q <= func;
					done_q <= 1'b0;
					hit_q <= 1'b0;
				end
				arsc_pkg::OP_READ: hit_q <= age_c < fill_c;
				arsc_pkg::OP_MOTION: begin
					if (session_q == 32'd0 && rtc_q != 32'd0) session_q <= rtc_q;
				end
				arsc_pkg::OP_ACC: begin
					square_sum_q <= square_sum_q + {16'd0, prod_q};
					window_count_q <= count_inc;
					close_q <= count_inc >= win_samples_q && count_inc != 16'd0;
				end
				arsc_pkg::OP_CLASSIFY: begin
					square_sum_q <= '0;
					window_count_q <= '0;
					if (stage_new != arsc_pkg::STAGE_AWAKE)
						sleep_q <= sleep_q + {16'd0, win_seconds_q};
					if (stage_new == arsc_pkg::STAGE_DEEP)
						deep_q <= deep_q + {16'd0, win_seconds_q};
					if (was_asleep_q && stage_new == arsc_pkg::STAGE_AWAKE)
						turns_q <= turns_q + 32'd1;
					was_asleep_q <= stage_new != arsc_pkg::STAGE_AWAKE;
					stage_q <= stage_new;
					head_q <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
					if (fill_q < DEPTH_F) fill_q <= fill_q + FW'(1);
					done_q <= 1'b1;
				end
				arsc_pkg::OP_MISC: begin
					if (func_q == arsc_pkg::FUNC_TOGGLE) begin
						mon_q <= !mon_q;
						if (!mon_q) begin
							session_q <= rtc_q;
							square_sum_q <= '0;
							window_count_q <= '0;
						end
					end else begin
						sleep_q <= '0;
						deep_q <= '0;
						turns_q <= '0;
						was_asleep_q <= 1'b0;
						fill_q <= '0;
						head_q <= '0;
						square_sum_q <= '0;
						window_count_q <= '0;
						stage_q <= arsc_pkg::STAGE_AWAKE;
						session_q <= rtc_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		case (cmd.op)
			arsc_pkg::OP_LOAD: begin
				ax_q <= accel_x;
				ay_q <= accel_y;
				az_q <= accel_z;
				rtc_q <= rtc_now;
				age_q <= hist_age;
				magsq_q <= '0;
				rms_q <= '0;
			end
			arsc_pkg::OP_SQ: begin
				prod_q <= mul_p[31:0];
				if (cmd.sel != 2'd0) magsq_q <= magsq_q + prod_q;
			end
			arsc_pkg::OP_SQRT_MAG: begin
				rad_q <= {16'd0, magsq_q};
				rem_q <= '0;
				root_q <= '0;
			end
			arsc_pkg::OP_SQRT_MEAN: begin
				rad_q <= dvd_q;
				rem_q <= '0;
				root_q <= '0;
			end
			arsc_pkg::OP_SQRT_STEP: begin
				rad_q <= {rad_q[45:0], 2'b00};
				rem_q <= sq_ge ? sq_rem - sq_trial : sq_rem;
				root_q <= {root_q[22:0], sq_ge};
			end
			arsc_pkg::OP_MOTION: prod_q <= mul_p[31:0];
			arsc_pkg::OP_DIV_INIT: begin
				dvd_q <= square_sum_q;
				drem_q <= '0;
			end
			arsc_pkg::OP_DIV_STEP: begin
				drem_q <= dv_ge ? 16'(dv_t - {1'b0, window_count_q}) : dv_t[15:0];
				dvd_q <= {dvd_q[46:0], dv_ge};
			end
			arsc_pkg::OP_CLASSIFY: rms_q <= rms_now;
			arsc_pkg::OP_OUT: begin
				window_done <= done_q;
				rms_level <= done_q ? rms_q : 16'd0;
				sleep_state <= stage_q;
				monitor_on <= mon_q;
				sleep_total <= sleep_q;
				deep_total <= deep_q;
				turns <= turns_q;
				slots_filled <= (fill_q > FW'(255)) ? 8'd255 : 8'(fill_q);
				session_begin <= session_q;
				slot_state <= (func_q == arsc_pkg::FUNC_READ && hit_q) ? rd_q[33:32] : 2'd0;
				slot_time <= (func_q == arsc_pkg::FUNC_READ && hit_q) ? rd_q[31:0] : 32'd0;
			end
			default: ;
		endcase
	end

	assign status.func = func_q;
	assign status.mon = mon_q;
	assign status.close = close_q;

endmodule
